FILE: hdl/wrsi_pkg.sv
package wrsi_pkg;

    // field widths and defaults
    localparam int SAMPLE_BITS           = 16;
    localparam int AVERAGE_FRACTION_BITS = 16;
    localparam int WINDOW_BITS           = 8;
    localparam int RSI_BITS              = 15;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 8'd14;
    localparam logic [WINDOW_BITS-1:0] SEEN_MAX     = 8'd255;

    // 100.0 with 8 fractional bits
    localparam logic [RSI_BITS-1:0] RSI_FULL_SCALE = 15'd25600;

    // ratio quotient never exceeds full scale, so this many quotient bits suffice
    localparam int RSI_RATIO_STEPS = RSI_BITS;

    // gain and loss are scaled down together until their sum fits this many bits
    localparam int RSI_SUM_LIMIT = 48;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hdl/wrsi_div.sv
module wrsi_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 8,
    parameter int STEPS = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [DVS_W-1:0]    i_divisor,
    output wrsi_pkg::t_div_stat o_stat,
    output logic [STEPS-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [STEPS-1:0] r_lo;
    logic [STEPS-1:0] n_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit per cycle; quotient bits shift into r_lo
    assign trial = {r_rem, r_lo[STEPS-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_rem = fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        n_lo  = {r_lo[STEPS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // upper dividend bits are below the divisor by construction at every call site
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dividend >> STEPS);
            r_lo  <= i_dividend[STEPS-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_lo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running division");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("step counter skipped");

endmodule

FILE: hdl/wilder_rsi_stream_core.sv
// Streaming Wilder RSI.
// Input channel i_valid/o_ready carries i_sample and i_start_of_series; the output
// channel o_valid/i_ready carries o_rsi_value (0..25600, 100.0 with 8 fraction bits).
// The period is written through i_cfg_we/i_cfg_wdata; the user must do so only while
// the block is idle, as the block does not enforce it; zero acts as a period of one.
// Samples inside the seed phase that produce no result leave the block idle.
// The sample that closes the seed phase and every later sample produce one result:
// the averages are divided by the period in two radix-2 lanes (one bit per cycle,
// AVG_W = SAMPLE_BITS + AVERAGE_FRACTION_BITS + 8 quotient bits, 40 at the defaults),
// then 100*G/(G+L) runs through a radix-2 divider for 15 quotient bits. While
// smoothing, the numerator is formed in S_MUL before the lanes start; the ratio is
// skipped when the loss average is zero, and very wide parameters add steps in S_NORM
// that halve G and L until their sum fits; one item is worked on at a time, so no
// new sample is taken until the result reaches the output register.
// The result sits in an output register: a stalled receiver does not block the next
// input transfer, and only a second result waits until the first is taken.
// Reset sets the period to 14, clears the averages and the sample count, and the
// first sample after reset starts a series.
module wilder_rsi_stream_core #(
    parameter int SAMPLE_BITS           = wrsi_pkg::SAMPLE_BITS,
    parameter int AVERAGE_FRACTION_BITS = wrsi_pkg::AVERAGE_FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wrsi_pkg::WINDOW_BITS-1:0] i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic                             i_start_of_series,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [wrsi_pkg::RSI_BITS-1:0]    o_rsi_value
);

    localparam int WB     = wrsi_pkg::WINDOW_BITS;
    localparam int GAIN_W = SAMPLE_BITS + AVERAGE_FRACTION_BITS;
    localparam int AVG_W  = GAIN_W + WB;
    localparam int SUM_W  = AVG_W + 1;
    localparam int NDVD_W = AVG_W + WB;
    localparam int RDVD_W = AVG_W + wrsi_pkg::RSI_RATIO_STEPS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIVN  = 6'b000100,
        S_NORM  = 6'b001000,
        S_RATIO = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [WB-1:0]          r_wl;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [WB-1:0]          r_seen;
    logic [AVG_W-1:0]       r_avg_g;
    logic [AVG_W-1:0]       r_avg_l;
    logic [GAIN_W-1:0]      r_gain;
    logic [GAIN_W-1:0]      r_loss;
    logic [AVG_W-1:0]       r_g;
    logic [AVG_W-1:0]       r_l;
    logic                   r_full;
    logic                   r_ovalid;
    logic [wrsi_pkg::RSI_BITS-1:0] r_out;

    logic                   acc;
    logic [WB-1:0]          n_eff;
    logic [WB-1:0]          idx;
    logic                   first;
    logic [GAIN_W-1:0]      gain;
    logic [GAIN_W-1:0]      loss;
    logic [AVG_W-1:0]       seed_g;
    logic [AVG_W-1:0]       seed_l;
    logic                   in_seed;
    logic                   seed_last;
    logic [NDVD_W-1:0]      smooth_g;
    logic [NDVD_W-1:0]      smooth_l;
    logic [SUM_W-1:0]       gl_sum;
    logic                   need_shift;
    logic                   emit_load;

    logic                   lane_start;
    logic [NDVD_W-1:0]      lane_dvd_g;
    logic [NDVD_W-1:0]      lane_dvd_l;
    wrsi_pkg::t_div_stat    lane_stat_g;
    wrsi_pkg::t_div_stat    lane_stat_l;
    logic [AVG_W-1:0]       q_g;
    logic [AVG_W-1:0]       q_l;

    logic                   ratio_start;
    logic [RDVD_W-1:0]      ratio_dvd;
    wrsi_pkg::t_div_stat    ratio_stat;
    logic [wrsi_pkg::RSI_RATIO_STEPS-1:0] q_ratio;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_eff   = (r_wl == '0) ? WB'(1) : r_wl;
        idx     = i_start_of_series ? '0 : r_seen;
        first   = (idx == '0);
        gain    = '0;
        loss    = '0;
        if (!first) begin
            if (i_sample > r_prev) begin
                gain = {i_sample - r_prev, {AVERAGE_FRACTION_BITS{1'b0}}};
            end else begin
                loss = {r_prev - i_sample, {AVERAGE_FRACTION_BITS{1'b0}}};
            end
        end
        seed_g    = (first ? '0 : r_avg_g) + AVG_W'(gain);
        seed_l    = (first ? '0 : r_avg_l) + AVG_W'(loss);
        in_seed   = (idx < n_eff);
        seed_last = (idx == n_eff - WB'(1));
    end

    // wilder smoothing numerator: avg*(n-1) + new term
    assign smooth_g = NDVD_W'(r_avg_g) * NDVD_W'(n_eff - WB'(1)) + NDVD_W'(r_gain);
    assign smooth_l = NDVD_W'(r_avg_l) * NDVD_W'(n_eff - WB'(1)) + NDVD_W'(r_loss);

    assign lane_start = (acc && in_seed && seed_last) || (r_state == S_MUL);
    assign lane_dvd_g = (r_state == S_MUL) ? smooth_g : NDVD_W'(seed_g);
    assign lane_dvd_l = (r_state == S_MUL) ? smooth_l : NDVD_W'(seed_l);

    assign gl_sum      = SUM_W'(r_g) + SUM_W'(r_l);
    assign need_shift  = ((gl_sum >> wrsi_pkg::RSI_SUM_LIMIT) != '0);
    assign ratio_start = (r_state == S_NORM) && !need_shift && (r_l != '0);
    assign ratio_dvd   = RDVD_W'(r_g) * RDVD_W'(wrsi_pkg::RSI_FULL_SCALE);

    assign emit_load = (r_state == S_EMIT) && (!r_ovalid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && !in_seed) begin
                    n_state = S_MUL;
                end else if (acc && seed_last) begin
                    n_state = S_DIVN;
                end
            end
            S_MUL: begin
                n_state = S_DIVN;
            end
            S_DIVN: begin
                if (lane_stat_g.done) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (!need_shift) begin
                    n_state = (r_l == '0) ? S_EMIT : S_RATIO;
                end
            end
            S_RATIO: begin
                if (ratio_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wl     <= wrsi_pkg::WINDOW_RESET;
            r_prev   <= '0;
            r_seen   <= '0;
            r_avg_g  <= '0;
            r_avg_l  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wl <= i_cfg_wdata;
            end
            if (acc) begin
                r_prev <= i_sample;
                r_seen <= (idx != wrsi_pkg::SEEN_MAX) ? idx + WB'(1) : wrsi_pkg::SEEN_MAX;
                if (in_seed) begin
                    r_avg_g <= seed_g;
                    r_avg_l <= seed_l;
                end
            end
            if ((r_state == S_DIVN) && lane_stat_g.done) begin
                r_avg_g <= q_g;
                r_avg_l <= q_l;
            end
            if (emit_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_gain <= gain;
            r_loss <= loss;
        end
        // working copies for the ratio; scaling must not touch the stored averages
        if ((r_state == S_DIVN) && lane_stat_g.done) begin
            r_g <= q_g;
            r_l <= q_l;
        end else if ((r_state == S_NORM) && need_shift) begin
            r_g <= r_g >> 1;
            r_l <= r_l >> 1;
        end
        if ((r_state == S_NORM) && !need_shift) begin
            r_full <= (r_l == '0);
        end
        if (emit_load) begin
            r_out <= r_full ? wrsi_pkg::RSI_FULL_SCALE : q_ratio;
        end
    end

    wrsi_div #(
        .DVD_W (NDVD_W),
        .DVS_W (WB),
        .STEPS (AVG_W)
    ) u_div_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_start),
        .i_dividend (lane_dvd_g),
        .i_divisor  (n_eff),
        .o_stat     (lane_stat_g),
        .o_quotient (q_g)
    );

    wrsi_div #(
        .DVD_W (NDVD_W),
        .DVS_W (WB),
        .STEPS (AVG_W)
    ) u_div_loss (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_start),
        .i_dividend (lane_dvd_l),
        .i_divisor  (n_eff),
        .o_stat     (lane_stat_l),
        .o_quotient (q_l)
    );

    wrsi_div #(
        .DVD_W (RDVD_W),
        .DVS_W (SUM_W),
        .STEPS (wrsi_pkg::RSI_RATIO_STEPS)
    ) u_div_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ratio_start),
        .i_dividend (ratio_dvd),
        .i_divisor  (gl_sum),
        .o_stat     (ratio_stat),
        .o_quotient (q_ratio)
    );

    assign o_valid     = r_ovalid;
    assign o_rsi_value = r_out;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_stat_g.done == lane_stat_l.done) && (lane_stat_g.busy == lane_stat_l.busy))
        else $error("gain and loss lanes out of step");

    a_seen_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_start_of_series && (r_seen != wrsi_pkg::SEEN_MAX))
        |=> (r_seen == $past(r_seen) + WB'(1)))
        else $error("sample count did not advance");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !r_full) |-> (q_ratio <= wrsi_pkg::RSI_FULL_SCALE))
        else $error("rsi ratio above full scale");

endmodule
